FILE: rtl/ack_delay_signal_tracker_defines.svh
// assertion macros for the ack delay signal tracker checker
// no dependencies
`ifndef ACK_DELAY_SIGNAL_TRACKER_DEFINES_SVH
`define ACK_DELAY_SIGNAL_TRACKER_DEFINES_SVH
// implication checked on every clock, quiet during reset
`define ADST_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
// next-cycle implication
`define ADST_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`endif

FILE: rtl/adst_pkg.sv
// shared constants and helpers for the ack delay signal tracker
// no dependencies
package adst_pkg;
	localparam int TIME_FRAC_BITS  = 16;
	localparam int RATIO_FRAC_BITS = 16;
	localparam int FAST_SHIFT      = 3;
	localparam int SLOW_SHIFT      = 8;
	localparam int TW = 48;
	localparam logic [47:0] M48 = 48'hFFFF_FFFF_FFFF;
	// divider request
	typedef struct packed {
		logic        start;
		logic [47:0] num;
		logic [47:0] den;
		logic [32:0] limit;
	} div_req_t;
	typedef struct packed {
		logic        done;
		logic [32:0] res;
	} div_rsp_t;
endpackage

FILE: rtl/adst_div.sv
// shared restoring divider: min(floor(num*2^R/den), limit), one bit per cycle
// depends on adst_pkg
module adst_div #(
	parameter int RATIO_FRAC_BITS = adst_pkg::RATIO_FRAC_BITS
) (
	input  logic              clk,
	input  logic              arst_n,
	input  adst_pkg::div_req_t req,
	output adst_pkg::div_rsp_t rsp
);
	localparam int NB = 48 + RATIO_FRAC_BITS;
	localparam int CW = $clog2(NB + 1);
	logic [NB-1:0] n_q;
	logic [48:0]   r_q;
	logic [NB-1:0] quo_q;
	logic [47:0]   d_q;
	logic [32:0]   lim_q;
	logic [CW-1:0] cnt_q;
	logic          busy_q, done_q;
	logic [48:0]   r_sh;
	logic [NB-1:0] quo_n;
	assign r_sh = {r_q[47:0], n_q[NB-1]};
	always_comb begin
		quo_n = {quo_q[NB-2:0], 1'b0};
		if (r_sh >= {1'b0, d_q}) quo_n[0] = 1'b1;
	end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(NB);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CW'(1);
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end
	always_ff @(posedge clk) begin
		if (req.start) begin
			n_q   <= {req.num, {RATIO_FRAC_BITS{1'b0}}};
			r_q   <= '0;
			quo_q <= '0;
			d_q   <= req.den;
			lim_q <= req.limit;
		end else if (busy_q) begin
			n_q   <= {n_q[NB-2:0], 1'b0};
			quo_q <= quo_n;
			r_q   <= quo_n[0] ? r_sh - {1'b0, d_q} : r_sh;
		end
	end
	assign rsp.done = done_q;
	assign rsp.res  = (quo_q > NB'(lim_q)) ? lim_q : quo_q[32:0];
endmodule

FILE: rtl/adst_mul.sv
// shared multiplier, 48 x 16, registered, saturating to 48 bits
// depends on adst_pkg
module adst_mul (
	input  logic        clk,
	input  logic [47:0] a,
	input  logic [15:0] b,
	output logic [47:0] p
);
	logic [63:0] prod;
	assign prod = 64'(a) * 64'(b);
	always_ff @(posedge clk) begin
		p <= (prod[63:48] != '0) ? adst_pkg::M48 : prod[47:0];
	end
endmodule

FILE: rtl/ack_delay_signal_tracker.sv
// ack delay signal tracker top level: sequencer, state and result register
// depends on adst_pkg, adst_div, adst_mul
// One acknowledged item is taken at a time and in_ready stays low while it is worked on.
// An item of another flow is dropped in the check state and the block returns to idle.
// The first tracked item seeds the RTT state; it passes CHK, MUL1, MUL1W, PEN and OUT.
// Every later item passes CHK, MUL1, MUL1W, PEN, UPD, MUL2, MUL2W, DIV1, DIV1W, DIV2,
// DIV2W and OUT, with two passes through the shared restoring divider, which retires
// one quotient bit per cycle; a pass is skipped when its divisor is zero. Products go
// through one shared registered multiplier. The result sits in an output register, so
// the next item is taken while the previous result waits; a further result holds in the
// last step until that register is free. The tracked flow id (own_q) is written through
// cfg while idle.
module ack_delay_signal_tracker #(
	parameter int TIME_FRAC_BITS  = adst_pkg::TIME_FRAC_BITS,
	parameter int RATIO_FRAC_BITS = adst_pkg::RATIO_FRAC_BITS,
	parameter int FAST_SHIFT      = adst_pkg::FAST_SHIFT,
	parameter int SLOW_SHIFT      = adst_pkg::SLOW_SHIFT
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [15:0] cfg_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [15:0] pkt_flow_id,
	input  logic [30:0] seq_num,
	input  logic signed [31:0] peak_ack,
	input  logic [31:0] sent_tick,
	input  logic [31:0] recv_tick,
	output logic        out_valid,
	input  logic        out_ready,
	output logic signed [47:0] send_gap_ewma,
	output logic [47:0] recv_gap_ewma,
	output logic [47:0] slow_recv_gap_ewma,
	output logic [31:0] rtt_scale,
	output logic [47:0] rtt_excess,
	output logic [47:0] queue_delay,
	output logic signed [31:0] send_recv_ratio,
	output logic        seeded_only
);
	localparam logic [3:0] ST_IDLE = 4'd0, ST_CHK = 4'd1, ST_MUL1 = 4'd2, ST_MUL1W = 4'd3,
		ST_PEN = 4'd4, ST_UPD = 4'd5, ST_MUL2 = 4'd6, ST_MUL2W = 4'd7, ST_DIV1 = 4'd8,
		ST_DIV1W = 4'd9, ST_DIV2 = 4'd10, ST_DIV2W = 4'd11, ST_OUT = 4'd12;
	localparam logic [47:0] SMAX = 48'h7FFF_FFFF_FFFF;

	logic [3:0] st_q;
	logic [15:0] own_q;
	logic seeded_q;
	// latched item
	logic [15:0] flow_q;
	logic [30:0] seq_q;
	logic signed [31:0] la_q;
	logic [31:0] ts_q, tr_q;
	// tracker state
	logic [31:0] pst_q, prt_q;
	logic [47:0] minr_q, srtt_q, rgap_q, srgap_q;
	logic signed [47:0] sgap_q;
	logic [47:0] d_excess_q, d_qdel_q;
	logic [31:0] d_ratio_q, d_sr_q;
	// work registers
	logic [47:0] rq_q, pen_q, mul_a;
	logic [15:0] outst_q, mul_b;
	logic [47:0] mul_p;
	logic neg_q;
	// output register
	logic ov_q, seed_out_q;

	adst_pkg::div_req_t dreq;
	adst_pkg::div_rsp_t drsp;

	adst_div #(.RATIO_FRAC_BITS(RATIO_FRAC_BITS)) u_div (
		.clk(clk), .arst_n(arst_n), .req(dreq), .rsp(drsp));
	adst_mul u_mul (.clk(clk), .a(mul_a), .b(mul_b), .p(mul_p));

	// rtt and outstanding count from the latched item
	logic [31:0] rtt_raw;
	logic [47:0] rq_c;
	logic signed [32:0] od;
	logic [15:0] outst_c;
	assign rtt_raw = tr_q - ts_q;
	assign rq_c = (rtt_raw >> (48 - TIME_FRAC_BITS)) != '0 ? adst_pkg::M48
		: 48'(64'(rtt_raw) << TIME_FRAC_BITS);
	assign od = 33'(signed'({1'b0, seq_q})) - 33'(la_q);
	assign outst_c = (od <= 0) ? 16'd1 : (od > 33'sd65535 ? 16'hFFFF : od[15:0]);

	// penalized rtt
	logic [48:0] pen_sum;
	logic [47:0] rtt_pen;
	assign pen_sum = {1'b0, rq_q} + {1'b0, mul_p};
	assign rtt_pen = pen_sum[48] ? adst_pkg::M48 : pen_sum[47:0];

	// gaps
	logic [31:0] sd, rg;
	logic signed [47:0] sx, sdiff, snew;
	logic signed [49:0] sfl, ssum;
	logic [47:0] rx;
	assign sd = ts_q - pst_q;
	assign rg = tr_q - prt_q;
	// sign extended 32-bit gap scaled stays in 48 bits when TIME_FRAC_BITS <= 16
	assign sx = (TIME_FRAC_BITS > 16) ?
		((signed'(sd) >>> (47 - TIME_FRAC_BITS)) > 0 ? signed'(SMAX) :
		 (signed'(sd) >>> (47 - TIME_FRAC_BITS)) < -1 ? signed'(~SMAX) :
		 48'(64'(signed'(sd)) <<< TIME_FRAC_BITS))
		: 48'(64'(signed'(sd)) <<< TIME_FRAC_BITS);
	assign rx = (rg >> (48 - TIME_FRAC_BITS)) != '0 ? adst_pkg::M48
		: 48'(64'(rg) << TIME_FRAC_BITS);
	assign sfl = (50'(sx) - 50'(sgap_q)) >>> FAST_SHIFT;
	assign ssum = 50'(sgap_q) + sfl;
	assign snew = ssum > 50'(signed'(SMAX)) ? signed'(SMAX)
		: (ssum < -50'sh800000000000 ? signed'(~SMAX) : ssum[47:0]);

	function automatic logic [47:0] ewma_u(input logic [47:0] avg, input logic [47:0] x,
			input int s);
		logic signed [49:0] d, r;
		begin
			// signed difference, so the shift floors toward minus infinity
			d = signed'(50'(x) - 50'(avg));
			d = d >>> s;
			r = 50'(avg) + d;
			ewma_u = r < 0 ? 48'd0 : r[47:0];
		end
	endfunction

	logic [47:0] rnew, srnew, srtt_new, min_new;
	assign rnew = ewma_u(rgap_q, rx, FAST_SHIFT);
	assign srnew = ewma_u(srgap_q, rx, SLOW_SHIFT);
	assign srtt_new = ewma_u(srtt_q, rq_q, FAST_SHIFT);
	assign min_new = rtt_pen < minr_q ? rtt_pen : minr_q;

	assign cfg_ready = (st_q == ST_IDLE);
	assign in_ready  = (st_q == ST_IDLE);

	always_comb begin
		mul_a = pen_q;
		mul_b = outst_q - 16'd1;
		if (st_q == ST_MUL2 || st_q == ST_MUL2W) begin
			mul_a = rgap_q;
			mul_b = outst_q;
		end
		dreq.start = 1'b0;
		dreq.num = pen_q;
		dreq.den = minr_q;
		dreq.limit = 33'hFFFF_FFFF;
		if (st_q == ST_DIV1) dreq.start = minr_q != '0;
		if (st_q == ST_DIV2) begin
			dreq.start = rgap_q != '0;
			dreq.num = neg_q ? 48'(-sgap_q) : sgap_q;
			dreq.den = rgap_q;
			dreq.limit = neg_q ? 33'h8000_0000 : 33'h7FFF_FFFF;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE;
			own_q <= '0;
			seeded_q <= 1'b0;
			ov_q <= 1'b0;
			pst_q <= '0; prt_q <= '0;
			minr_q <= '0; srtt_q <= '0; rgap_q <= '0; srgap_q <= '0; sgap_q <= '0;
			d_ratio_q <= '0; d_excess_q <= '0; d_qdel_q <= '0; d_sr_q <= '0;
		end else begin
			// output register loads in the last step, empties on acceptance
			if (st_q == ST_OUT && (!ov_q || out_ready)) ov_q <= 1'b1;
			else if (out_ready) ov_q <= 1'b0;
			case (st_q)
				ST_IDLE: begin
					if (cfg_valid) own_q <= cfg_data;
					if (in_valid) st_q <= ST_CHK;
				end
				ST_CHK: begin
					st_q <= (flow_q == own_q) ? ST_MUL1 : ST_IDLE;
				end
				ST_MUL1: st_q <= ST_MUL1W;
				ST_MUL1W: st_q <= ST_PEN;
				ST_PEN: begin
					if (!seeded_q) begin
						pst_q <= ts_q; prt_q <= tr_q;
						minr_q <= rtt_pen; srtt_q <= rtt_pen;
						seeded_q <= 1'b1;
						st_q <= ST_OUT;
					end else st_q <= ST_UPD;
				end
				ST_UPD: begin
					sgap_q <= snew; rgap_q <= rnew; srgap_q <= srnew;
					pst_q <= ts_q; prt_q <= tr_q;
					srtt_q <= srtt_new; minr_q <= min_new;
					d_excess_q <= pen_q - min_new;
					st_q <= ST_MUL2;
				end
				ST_MUL2: st_q <= ST_MUL2W;
				ST_MUL2W: begin
					d_qdel_q <= mul_p;
					st_q <= ST_DIV1;
				end
				ST_DIV1: begin
					d_ratio_q <= 32'hFFFF_FFFF;
					st_q <= (minr_q != '0) ? ST_DIV1W : ST_DIV2;
				end
				ST_DIV1W: if (drsp.done) begin
					d_ratio_q <= drsp.res[31:0];
					st_q <= ST_DIV2;
				end
				ST_DIV2: begin
					d_sr_q <= neg_q ? 32'h8000_0000 : 32'h7FFF_FFFF;
					st_q <= (rgap_q != '0) ? ST_DIV2W : ST_OUT;
				end
				ST_DIV2W: if (drsp.done) begin
					d_sr_q <= neg_q ? 32'(33'h1_0000_0000 - drsp.res) : drsp.res[31:0];
					st_q <= ST_OUT;
				end
				ST_OUT: begin
					// wait until the output register is free
					if (!ov_q || out_ready) st_q <= ST_IDLE;
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (st_q == ST_IDLE && in_valid) begin
			flow_q <= pkt_flow_id; seq_q <= seq_num; la_q <= peak_ack;
			ts_q <= sent_tick; tr_q <= recv_tick;
		end
		if (st_q == ST_CHK) begin
			rq_q <= rq_c;
			pen_q <= seeded_q ? srtt_q : rq_c;
			outst_q <= outst_c;
		end
		if (st_q == ST_PEN) pen_q <= rtt_pen;
		if (st_q == ST_UPD) neg_q <= snew < 0;
		if (st_q == ST_PEN) seed_out_q <= !seeded_q;
		if (st_q == ST_OUT && (!ov_q || out_ready)) begin
			send_gap_ewma <= sgap_q; recv_gap_ewma <= rgap_q;
			slow_recv_gap_ewma <= srgap_q; rtt_scale <= d_ratio_q;
			rtt_excess <= d_excess_q; queue_delay <= d_qdel_q;
			send_recv_ratio <= d_sr_q; seeded_only <= seed_out_q;
		end
	end
	assign out_valid = ov_q;
endmodule

FILE: rtl/adst_checker.sv
// port-level checker for the ack delay signal tracker, with its bind
// depends on ack_delay_signal_tracker_defines.svh
`include "ack_delay_signal_tracker_defines.svh"
module adst_checker (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_ready,
	input logic cfg_ready,
	input logic out_valid,
	input logic out_ready,
	input logic seeded_only,
	input logic [31:0] rtt_scale
);
	`ADST_ASSERT_NEXT(a_busy, clk, arst_n, in_valid && in_ready, !in_ready, "ready after item")
	`ADST_ASSERT_IMPL(a_cfg_with_in, clk, arst_n, 1'b1, cfg_ready == in_ready, "ready differ")
	`ADST_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(rtt_scale), "output dropped")
	`ADST_ASSERT_NEXT(a_seed_hold, clk, arst_n, out_valid && !out_ready, $stable(seeded_only), "seed flag changed")
endmodule

bind ack_delay_signal_tracker adst_checker u_adst_checker (
	.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
	.cfg_ready(cfg_ready), .out_valid(out_valid), .out_ready(out_ready),
	.seeded_only(seeded_only), .rtt_scale(rtt_scale));

FILE: bench/ack_delay_signal_tracker_tb.sv
// self-checking bench for the ack delay signal tracker: directed then random ack items
// depends on adst_pkg and ack_delay_signal_tracker
module ack_delay_signal_tracker_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [47:0] SMAX = 48'h7FFF_FFFF_FFFF;
	localparam int IDLE_PCT = 18;
	localparam int STALL_LIMIT = 20000;
	localparam int TAIL_CYCLES = 400;

	typedef struct {
		logic [15:0] flow;
		logic [30:0] seq;
		logic signed [31:0] lack;
		logic [31:0] ts;
		logic [31:0] tr;
	} ack_item_t;

	typedef struct {
		logic signed [47:0] sgap;
		logic [47:0] rgap;
		logic [47:0] slow_rgap;
		logic [31:0] ratio;
		logic [47:0] excess;
		logic [47:0] qdelay;
		logic signed [31:0] sr_ratio;
		logic seeded;
	} signals_t;

	logic clk, arst_n;
	logic cfg_valid, cfg_ready;
	logic [15:0] cfg_data;
	logic in_valid, in_ready;
	logic [15:0] pkt_flow_id;
	logic [30:0] seq_num;
	logic signed [31:0] peak_ack;
	logic [31:0] sent_tick, recv_tick;
	logic out_valid, out_ready;
	logic signed [47:0] send_gap_ewma;
	logic [47:0] recv_gap_ewma, slow_recv_gap_ewma, rtt_excess, queue_delay;
	logic [31:0] rtt_scale;
	logic signed [31:0] send_recv_ratio;
	logic seeded_only;

	ack_delay_signal_tracker i_dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_ready(in_ready),
		.pkt_flow_id(pkt_flow_id), .seq_num(seq_num), .peak_ack(peak_ack),
		.sent_tick(sent_tick), .recv_tick(recv_tick),
		.out_valid(out_valid), .out_ready(out_ready),
		.send_gap_ewma(send_gap_ewma), .recv_gap_ewma(recv_gap_ewma),
		.slow_recv_gap_ewma(slow_recv_gap_ewma), .rtt_scale(rtt_scale),
		.rtt_excess(rtt_excess), .queue_delay(queue_delay),
		.send_recv_ratio(send_recv_ratio), .seeded_only(seeded_only)
	);

	// tracker state mirrored in the bench
	logic [15:0] tracked_flow;
	logic [31:0] last_send, last_recv;
	logic [47:0] rtt_floor, rtt_smooth, rgap_avg, slow_rgap_avg;
	logic signed [47:0] sgap_avg;
	signals_t held;
	logic is_seeded;

	ack_item_t pending_acks[$];
	signals_t expected_signals[$];
	int errors, accepted, results, ignored, seeds;
	logic quiet;	// idling disabled while set
	logic hold_send;	// sender held off by the stimulus process

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// floor division by a power of two on a signed value
	function automatic logic signed [63:0] floor_shr(logic signed [63:0] d, int s);
		return d >>> s;
	endfunction

	function automatic logic [47:0] avg_step(logic [47:0] avg, logic [47:0] x, int s);
		logic signed [63:0] r;
		r = $signed({16'd0, avg}) + floor_shr($signed({16'd0, x}) - $signed({16'd0, avg}), s);
		if (r < 0) return 48'd0;
		if (r > $signed({16'd0, adst_pkg::M48})) return adst_pkg::M48;
		return r[47:0];
	endfunction

	// saturating fixed-point quotient, den nonzero
	function automatic logic [63:0] frac_quot(logic [47:0] num, logic [47:0] den,
			logic [63:0] limit);
		logic [127:0] q;
		q = ({80'd0, num} << adst_pkg::RATIO_FRAC_BITS) / {80'd0, den};
		return (q > {64'd0, limit}) ? limit : q[63:0];
	endfunction

	function automatic logic [47:0] sat_mul(logic [47:0] a, logic [47:0] b);
		logic [95:0] p;
		p = {48'd0, a} * {48'd0, b};
		return (p > {48'd0, adst_pkg::M48}) ? adst_pkg::M48 : p[47:0];
	endfunction

	task automatic track_ack(input ack_item_t a);
		logic [47:0] rq, pen, outst, rpen, rx, mag;
		logic [48:0] sum;
		logic signed [63:0] seq_diff, sx, ns;
		logic [31:0] sd, rg;
		signals_t r;
		if (a.flow != tracked_flow) begin
			ignored++;
			return;
		end
		rq = {a.tr - a.ts, 16'd0};
		seq_diff = $signed({33'd0, a.seq}) - $signed({{32{a.lack[31]}}, a.lack});
		outst = 48'd1;
		if (seq_diff > 0) outst = (seq_diff > 65535) ? 48'd65535 : seq_diff[47:0];
		pen = is_seeded ? rtt_smooth : rq;
		sum = {1'b0, rq} + {1'b0, sat_mul(pen, outst - 48'd1)};
		rpen = sum[48] ? adst_pkg::M48 : sum[47:0];
		if (!is_seeded) begin
			last_send = a.ts;
			last_recv = a.tr;
			rtt_floor = rpen;
			rtt_smooth = rpen;
			is_seeded = 1'b1;
			seeds++;
			r = held;
			r.seeded = 1'b1;
		end else begin
			sd = a.ts - last_send;
			rg = a.tr - last_recv;
			sx = $signed({{32{sd[31]}}, sd}) * 65536;
			rx = {rg, 16'd0};
			ns = $signed({{16{sgap_avg[47]}}, sgap_avg}) +
				floor_shr(sx - $signed({{16{sgap_avg[47]}}, sgap_avg}), adst_pkg::FAST_SHIFT);
			if (ns > $signed({16'd0, SMAX})) sgap_avg = SMAX;
			else if (ns < -$signed({16'd0, SMAX}) - 1) sgap_avg = ~SMAX;
			else sgap_avg = ns[47:0];
			rgap_avg = avg_step(rgap_avg, rx, adst_pkg::FAST_SHIFT);
			slow_rgap_avg = avg_step(slow_rgap_avg, rx, adst_pkg::SLOW_SHIFT);
			if (rgap_avg == 0)
				held.sr_ratio = (sgap_avg >= 0) ? 32'h7FFF_FFFF : 32'h8000_0000;
			else if (sgap_avg >= 0)
				held.sr_ratio = 32'(frac_quot(sgap_avg, rgap_avg, 64'h7FFF_FFFF));
			else begin
				mag = -sgap_avg;
				held.sr_ratio = 32'(64'd0 - frac_quot(mag, rgap_avg, 64'h8000_0000));
			end
			last_send = a.ts;
			last_recv = a.tr;
			rtt_smooth = avg_step(rtt_smooth, rq, adst_pkg::FAST_SHIFT);
			if (rpen < rtt_floor) rtt_floor = rpen;
			held.ratio = (rtt_floor == 0) ? 32'hFFFF_FFFF :
				32'(frac_quot(rpen, rtt_floor, 64'hFFFF_FFFF));
			held.excess = rpen - rtt_floor;
			held.qdelay = sat_mul(rgap_avg, outst);
			held.sgap = sgap_avg;
			held.rgap = rgap_avg;
			held.slow_rgap = slow_rgap_avg;
			r = held;
			r.seeded = 1'b0;
		end
		expected_signals.push_back(r);
	endtask

	// driver: one queued item at a time, random idle gaps
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			pkt_flow_id <= '0;
			seq_num <= '0;
			peak_ack <= '0;
			sent_tick <= '0;
			recv_tick <= '0;
		end else if (!in_valid || in_ready) begin
			if (in_valid && in_ready) begin
				track_ack(pending_acks.pop_front());
				accepted++;
			end
			if (pending_acks.size() > 0 && !hold_send &&
					(quiet || $urandom_range(99) >= IDLE_PCT)) begin
				in_valid <= 1'b1;
				pkt_flow_id <= pending_acks[0].flow;
				seq_num <= pending_acks[0].seq;
				peak_ack <= pending_acks[0].lack;
				sent_tick <= pending_acks[0].ts;
				recv_tick <= pending_acks[0].tr;
			end else
				in_valid <= 1'b0;
		end
	end

	// monitor: compare each result against the oldest expectation
	always @(posedge clk or negedge arst_n) begin
		signals_t e;
		if (!arst_n)
			out_ready <= 1'b0;
		else begin
			if (out_valid && out_ready) begin
				results++;
				if (expected_signals.size() == 0) begin
					$display("%0t: unexpected result, expected none, got send_gap %h",
						$time, send_gap_ewma);
					errors++;
				end else begin
					e = expected_signals.pop_front();
					if (send_gap_ewma !== e.sgap) begin
						$display("%0t: send_gap_ewma exp %h got %h", $time, e.sgap, send_gap_ewma);
						errors++;
					end
					if (recv_gap_ewma !== e.rgap) begin
						$display("%0t: recv_gap_ewma exp %h got %h", $time, e.rgap, recv_gap_ewma);
						errors++;
					end
					if (slow_recv_gap_ewma !== e.slow_rgap) begin
						$display("%0t: slow_recv_gap_ewma exp %h got %h", $time, e.slow_rgap,
							slow_recv_gap_ewma);
						errors++;
					end
					if (rtt_scale !== e.ratio) begin
						$display("%0t: rtt_scale exp %h got %h", $time, e.ratio, rtt_scale);
						errors++;
					end
					if (rtt_excess !== e.excess) begin
						$display("%0t: rtt_excess exp %h got %h", $time, e.excess, rtt_excess);
						errors++;
					end
					if (queue_delay !== e.qdelay) begin
						$display("%0t: queue_delay exp %h got %h", $time, e.qdelay, queue_delay);
						errors++;
					end
					if (send_recv_ratio !== e.sr_ratio) begin
						$display("%0t: send_recv_ratio exp %h got %h", $time, e.sr_ratio,
							send_recv_ratio);
						errors++;
					end
					if (seeded_only !== e.seeded) begin
						$display("%0t: seeded_only exp %b got %b", $time, e.seeded, seeded_only);
						errors++;
					end
				end
			end
			out_ready <= quiet || ($urandom_range(99) >= IDLE_PCT);
		end
	end

	// watchdog on cycles with no handshake at all
	int stall_cycles;
	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
				(cfg_valid && cfg_ready))
			stall_cycles <= 0;
		else begin
			stall_cycles <= stall_cycles + 1;
			if (stall_cycles == STALL_LIMIT) begin
				$display("FAIL ack_delay_signal_tracker");
				$finish;
			end
		end
	end

	function automatic ack_item_t make_ack(logic [15:0] flow, logic [30:0] seq,
			logic [31:0] lack, logic [31:0] ts, logic [31:0] tr);
		ack_item_t a;
		a.flow = flow; a.seq = seq; a.lack = lack; a.ts = ts; a.tr = tr;
		return a;
	endfunction

	// plausible ack stream: ticks advance, small in-flight window
	logic [31:0] clock_tick;
	function automatic ack_item_t flow_ack(logic [15:0] flow);
		ack_item_t a;
		logic [31:0] rtt;
		int r;
		r = $urandom_range(99);
		clock_tick = clock_tick + $urandom_range(40);
		rtt = (r < 5) ? 32'd0 : $urandom_range(500, 1);
		a.flow = flow;
		a.seq = 31'($urandom);
		a.lack = {1'b0, a.seq} - $urandom_range(20);
		if (r >= 90) a.lack = $urandom;	// broken window
		a.tr = clock_tick;
		a.ts = clock_tick - rtt;
		if (r >= 95) begin
			a.ts = $urandom;
			a.tr = $urandom;
		end
		return a;
	endfunction

	// wait until the block is drained, then let in-flight ignored items settle
	task automatic drain;
		while (pending_acks.size() > 0 || in_valid || expected_signals.size() > 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
	endtask

	task automatic write_flow(logic [15:0] flow);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= flow;
		do @(posedge clk); while (!cfg_ready);
		tracked_flow = flow;
		cfg_valid <= 1'b0;
	endtask

	task automatic random_phase(logic [15:0] flow, int n);
		ack_item_t a;
		repeat (n) begin
			a = flow_ack(flow);
			if ($urandom_range(99) < 15) a.flow = 16'($urandom);	// foreign flow noise
			pending_acks.push_back(a);
		end
	endtask

	initial begin
		logic [15:0] flows[4];
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		quiet = 1'b0;
		hold_send = 1'b0;
		errors = 0; accepted = 0; results = 0; ignored = 0; seeds = 0;
		clock_tick = 32'd1000;
		tracked_flow = '0;
		last_send = '0; last_recv = '0;
		rtt_floor = '0; rtt_smooth = '0; rgap_avg = '0; slow_rgap_avg = '0; sgap_avg = '0;
		held = '{default: '0};
		is_seeded = 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// directed: reset flow 0, seeding, extremes, zero gaps, wraps, foreign flows
		pending_acks.push_back(make_ack(16'hFFFF, 31'd5, 32'd0, 32'd10, 32'd20));
		pending_acks.push_back(make_ack(16'd0, 31'd10, 32'd5, 32'd100, 32'd150));
		pending_acks.push_back(make_ack(16'd0, 31'd11, 32'd10, 32'd100, 32'd150));
		pending_acks.push_back(make_ack(16'd0, 31'd12, 32'd11, 32'd90, 32'd150));
		pending_acks.push_back(make_ack(16'd0, 31'h7FFF_FFFF, 32'h8000_0000,
			32'h0, 32'hFFFF_FFFF));
		pending_acks.push_back(make_ack(16'd0, 31'd0, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h0));
		pending_acks.push_back(make_ack(16'd0, 31'd3, 32'hFFFF_FFFF, 32'h5, 32'h5));
		pending_acks.push_back(make_ack(16'd0, 31'd70000, 32'd0, 32'h10, 32'h20));
		pending_acks.push_back(make_ack(16'd0, 31'h5555_5555, 32'hAAAA_AAAA,
			32'h5555_5555, 32'hAAAA_AAAA));
		pending_acks.push_back(make_ack(16'd0, 31'h2AAA_AAAA, 32'h5555_5555,
			32'hAAAA_AAAA, 32'h5555_5555));
		pending_acks.push_back(make_ack(16'd1, 31'd1, 32'd0, 32'd1, 32'd2));
		drain();

		// fresh seeding needs a reset, so the remaining phases switch flows on the
		// already seeded tracker; the maximum flow id is one of them
		flows[0] = 16'hFFFF; flows[1] = 16'($urandom); flows[2] = 16'd0; flows[3] = 16'h8001;
		for (int p = 0; p < 4; p++) begin
			write_flow(flows[p]);
			if (p == 1) quiet = 1'b1;
			random_phase(flows[p], 170);
			if (p == 2) begin
				// sender holds off until every expected result is back
				while (pending_acks.size() > 85) @(posedge clk);
				hold_send = 1'b1;
				while (expected_signals.size() > 0 || in_valid) @(posedge clk);
				hold_send = 1'b0;
			end
			drain();
			quiet = 1'b0;
		end

		$display("covered %0d accepted items, %0d results, %0d ignored, %0d seeding",
			accepted, results, ignored, seeds);
		$display("four tracked flows including id extremes, with random idling on both sides");
		if (errors == 0)
			$display("PASS ack_delay_signal_tracker");
		else
			$display("FAIL ack_delay_signal_tracker");
		$finish;
	end
endmodule

FILE: files.f
+incdir+rtl
rtl/adst_pkg.sv
rtl/adst_div.sv
rtl/adst_mul.sv
rtl/ack_delay_signal_tracker.sv
rtl/adst_checker.sv
bench/ack_delay_signal_tracker_tb.sv
